FILE: hdl/first_fit_extent_allocator_core_macros.svh
// Assertion macros for the first-fit extent allocator core.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH
// same-cycle implication
`define FFEA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FFEA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hdl/ffea_pkg.sv
// Package: types and constants of the first-fit extent allocator.
`timescale 1ns / 1ps
package ffea_pkg;
	localparam int LIST_DEPTH = 32;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int POS_W      = 20;
	localparam int SIZE_W     = 21;
	localparam int WORD_W     = POS_W + SIZE_W;
	localparam logic [SIZE_W-1:0] ADDR_SPAN = 21'h100000;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_FULL   = 2'd2,
		ST_ZERO   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_CMP_RD,
		S_CMP_WR,
		S_FREE_WR
	} state_t;

	typedef enum logic [1:0] {
		P_ALLOC,
		P_LOW,
		P_HIGH
	} pass_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_ctl_t;
endpackage

FILE: hdl/ffea_list_ram.sv
// Free extent list storage: one write and one registered read per cycle.
`timescale 1ns / 1ps
module ffea_list_ram import ffea_pkg::*; (
	input  logic              clk,
	input  ram_ctl_t          ctl,
	output logic [WORD_W-1:0] rdata
);
	logic [WORD_W-1:0] mem [LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata <= mem[ctl.raddr];
		end
	end
endmodule

FILE: hdl/first_fit_extent_allocator_core.sv
// Top level: first-fit extent allocator with free-list coalescing.
// Usage:
//  s_axis carries one request per transfer; m_axis returns exactly one result.
//  cfg_we/cfg_wdata write pool_limit; write only while the core is idle.
//  Requests are handled one at a time by a sequencer around the list RAM,
//  which reads one entry per cycle and returns it from a registered output.
//  Zero-size, clear, list-full and unused requests load the result register
//  at the transfer itself. Allocate scans the entries in order, and when an
//  extent is emptied it moves the later entries down to remove it.
//  Free scans the list twice, once per neighbour, and compacts after a merge.
//  A new request is taken while the previous result still waits in the
//  output register, as long as that result leaves in the same cycle.
//  If the receiver stalls, the result is held and no new request is taken.
//  Reset empties the list, sets the bump top to zero and pool_limit to 2^20.
`timescale 1ns / 1ps
module first_fit_extent_allocator_core import ffea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [20:0] cfg_wdata,   // pool_limit
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata, // operation[1:0], req_size[22:2], free_pos[42:23]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata  // grant_pos[19:0], grant_size[40:20], status[42:41]
);
	`include "first_fit_extent_allocator_core_macros.svh"

	state_t state_q, state_d;
	pass_t  pass_q, pass_d;
	logic [CNT_W-1:0]  count_q, count_d, idx_q, idx_d;
	logic [SIZE_W-1:0] top_q, top_d, limit_q;
	logic [SIZE_W-1:0] size_q, size_d, cur_len_q, cur_len_d, fend_q, fend_d;
	logic [POS_W-1:0]  cur_start_q, cur_start_d, grant_q, grant_d;
	logic              out_valid_q, out_load;
	logic [POS_W-1:0]  out_pos_q, out_pos_d;
	logic [SIZE_W-1:0] out_size_q, out_size_d;
	status_t           out_status_q, out_status_d;
	ram_ctl_t          ram_ctl;
	logic [WORD_W-1:0] rdata;

	logic [1:0]        in_op;
	logic [SIZE_W-1:0] in_size, avail, clip_size, eff_limit;
	logic [POS_W-1:0]  in_pos, rd_start;
	logic [SIZE_W-1:0] rd_len, rem_len;
	logic [SIZE_W:0]   rd_end, bump_sum;
	logic              s_fire, last_move;

	assign in_op   = s_axis_tdata[1:0];
	assign in_size = s_axis_tdata[22:2];
	assign in_pos  = s_axis_tdata[42:23];
	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign s_fire  = s_axis_tvalid && s_axis_tready;

	assign avail     = ADDR_SPAN - {1'b0, in_pos};
	assign clip_size = (in_size > avail) ? avail : in_size;
	assign eff_limit = (limit_q > ADDR_SPAN) ? ADDR_SPAN : limit_q;
	assign rd_start  = rdata[POS_W-1:0];
	assign rd_len    = rdata[WORD_W-1:POS_W];
	assign rd_end    = {2'b00, rd_start} + {1'b0, rd_len};
	assign rem_len   = rd_len - size_q;
	assign bump_sum  = {1'b0, top_q} + {1'b0, size_q};
	assign last_move = (idx_q + 1'b1) >= count_q;

	ffea_list_ram u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.rdata (rdata)
	);

	always_comb begin
		state_d      = state_q;
		pass_d       = pass_q;
		count_d      = count_q;
		idx_d        = idx_q;
		top_d        = top_q;
		size_d       = size_q;
		cur_len_d    = cur_len_q;
		cur_start_d  = cur_start_q;
		fend_d       = fend_q;
		grant_d      = grant_q;
		out_load     = 1'b0;
		out_pos_d    = '0;
		out_size_d   = '0;
		out_status_d = ST_OK;
		ram_ctl      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					out_load = 1'b1;
					idx_d    = '0;
					size_d   = in_size;
					unique case (in_op)
						OP_ALLOC: begin
							if (in_size == '0) begin
								out_status_d = ST_ZERO;
							end else begin
								out_load = 1'b0;
								pass_d   = P_ALLOC;
								state_d  = S_SCAN_RD;
							end
						end
						OP_FREE: begin
							if (in_size == '0) begin
								out_status_d = ST_ZERO;
							end else if (count_q == CNT_W'(LIST_DEPTH)) begin
								out_status_d = ST_FULL;
							end else begin
								out_load    = 1'b0;
								cur_start_d = in_pos;
								cur_len_d   = clip_size;
								fend_d      = {1'b0, in_pos} + clip_size;
								pass_d      = P_LOW;
								state_d     = S_SCAN_RD;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
							top_d   = '0;
						end
						default: ;
					endcase
				end
			end
			S_SCAN_RD: begin
				if (idx_q == count_q) begin
					unique case (pass_q)
						P_ALLOC: begin
							out_load = 1'b1;
							state_d  = S_IDLE;
							if (bump_sum > {1'b0, eff_limit}) begin
								out_status_d = ST_NOSPACE;
							end else begin
								out_pos_d  = top_q[POS_W-1:0];
								out_size_d = size_q;
								top_d      = bump_sum[SIZE_W-1:0];
							end
						end
						P_LOW: begin
							pass_d = P_HIGH;
							idx_d  = '0;
						end
						default: state_d = S_FREE_WR;
					endcase
				end else begin
					ram_ctl.re    = 1'b1;
					ram_ctl.raddr = idx_q[IDX_W-1:0];
					state_d       = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				state_d = S_SCAN_RD;
				idx_d   = idx_q + 1'b1;
				unique case (pass_q)
					P_ALLOC: begin
						if (rd_len >= size_q) begin
							idx_d   = idx_q;
							grant_d = rd_start;
							if (rem_len == '0) begin
								state_d = S_CMP_RD;
							end else begin
								ram_ctl.we    = 1'b1;
								ram_ctl.waddr = idx_q[IDX_W-1:0];
								ram_ctl.wdata = {rem_len, rd_start + size_q[POS_W-1:0]};
								out_load      = 1'b1;
								out_pos_d     = rd_start;
								out_size_d    = size_q;
								state_d       = S_IDLE;
							end
						end
					end
					P_LOW: begin
						if (rd_end == {2'b00, cur_start_q}) begin
							idx_d       = idx_q;
							cur_len_d   = ({1'b0, cur_start_q} + cur_len_q) - {1'b0, rd_start};
							cur_start_d = rd_start;
							state_d     = S_CMP_RD;
						end
					end
					default: begin
						if ({1'b0, rd_start} == fend_q) begin
							idx_d     = idx_q;
							cur_len_d = rd_end[SIZE_W-1:0] - {1'b0, cur_start_q};
							state_d   = S_CMP_RD;
						end
					end
				endcase
			end
			S_CMP_RD: begin
				if (last_move) begin
					count_d = count_q - 1'b1;
					idx_d   = '0;
					unique case (pass_q)
						P_ALLOC: begin
							out_load   = 1'b1;
							out_pos_d  = grant_q;
							out_size_d = size_q;
							state_d    = S_IDLE;
						end
						P_LOW: begin
							pass_d  = P_HIGH;
							state_d = S_SCAN_RD;
						end
						default: state_d = S_FREE_WR;
					endcase
				end else begin
					ram_ctl.re    = 1'b1;
					ram_ctl.raddr = IDX_W'(idx_q + 1'b1);
					state_d       = S_CMP_WR;
				end
			end
			S_CMP_WR: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = idx_q[IDX_W-1:0];
				ram_ctl.wdata = rdata;
				idx_d         = idx_q + 1'b1;
				state_d       = S_CMP_RD;
			end
			S_FREE_WR: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = count_q[IDX_W-1:0];
				ram_ctl.wdata = {cur_len_q, cur_start_q};
				count_d       = count_q + 1'b1;
				out_load      = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= P_ALLOC;
			count_q     <= '0;
			idx_q       <= '0;
			top_q       <= '0;
			limit_q     <= ADDR_SPAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			top_q   <= top_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		size_q      <= size_d;
		cur_len_q   <= cur_len_d;
		cur_start_q <= cur_start_d;
		fend_q      <= fend_d;
		grant_q     <= grant_d;
		if (out_load) begin
			out_pos_q    <= out_pos_d;
			out_size_q   <= out_size_d;
			out_status_q <= out_status_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_status_q, out_size_q, out_pos_q};

	`FFEA_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(LIST_DEPTH), "list count overflow")
	`FFEA_ASSERT_IMP(a_load_free, out_load, !out_valid_q || m_axis_tready, "result overwritten")
	`FFEA_ASSERT_NXT(a_zero_nogrant, out_load && out_status_d != ST_OK, out_size_q == '0, "grant on error")
endmodule

FILE: test/tb_first_fit_extent_allocator_core.sv
// Testbench: random and directed requests checked against a first-fit free-list predictor.
`timescale 1ns / 1ps
module tb_first_fit_extent_allocator_core;
	import ffea_pkg::*;

	typedef struct {
		logic [19:0] pos;
		logic [20:0] size;
		status_t     st;
	} grant_t;

	class alloc_scoreboard;
		int unsigned ext_pos[LIST_DEPTH];
		int unsigned ext_len[LIST_DEPTH];
		int unsigned ext_cnt;
		int unsigned top;
		int unsigned limit;
		grant_t      pending[$];
		grant_t      last;
		int          errors;
		int          checked;

		function new();
			ext_cnt = 0;
			top = 0;
			limit = 1048576;
			errors = 0;
			checked = 0;
		endfunction

		task report(input string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		function void drop_entry(input int unsigned idx);
			for (int unsigned i = idx; i + 1 < ext_cnt; i++) begin
				ext_pos[i] = ext_pos[i + 1];
				ext_len[i] = ext_len[i + 1];
			end
			ext_cnt--;
		endfunction

		function void set_limit(input logic [20:0] v);
			limit = {11'b0, v};
		endfunction

		// compute the response for one accepted request and queue it
		function void note_request(input op_t op, input logic [20:0] req, input logic [19:0] fpos);
			int unsigned sz, lim, fend, lst;
			bit          done;
			grant_t      g;
			sz = {11'b0, req};
			done = 0;
			g.pos = 0;
			g.size = 0;
			g.st = ST_OK;
			case (op)
				OP_ALLOC: begin
					if (sz == 0) begin
						g.st = ST_ZERO;
					end else begin
						for (int unsigned i = 0; i < ext_cnt && !done; i++) begin
							if (ext_len[i] >= sz) begin
								g.pos = 20'(ext_pos[i]);
								g.size = 21'(sz);
								ext_pos[i] += sz;
								ext_len[i] -= sz;
								if (ext_len[i] == 0)
									drop_entry(i);
								done = 1;
							end
						end
						if (!done) begin
							lim = (limit > 1048576) ? 1048576 : limit;
							if (top + sz > lim) begin
								g.st = ST_NOSPACE;
							end else begin
								g.pos = 20'(top);
								g.size = 21'(sz);
								top += sz;
							end
						end
					end
				end
				OP_FREE: begin
					if (sz == 0) begin
						g.st = ST_ZERO;
					end else if (ext_cnt >= LIST_DEPTH) begin
						g.st = ST_FULL;
					end else begin
						if (sz > 1048576 - fpos)
							sz = 1048576 - fpos;
						fend = fpos + sz;
						ext_pos[ext_cnt] = fpos;
						ext_len[ext_cnt] = sz;
						ext_cnt++;
						for (int unsigned i = 0; i + 1 < ext_cnt && !done; i++) begin
							if (ext_pos[i] + ext_len[i] == fpos) begin
								lst = ext_cnt - 1;
								ext_len[lst] = ext_pos[lst] + ext_len[lst] - ext_pos[i];
								ext_pos[lst] = ext_pos[i];
								drop_entry(i);
								done = 1;
							end
						end
						done = 0;
						for (int unsigned i = 0; i + 1 < ext_cnt && !done; i++) begin
							if (ext_pos[i] == fend) begin
								lst = ext_cnt - 1;
								ext_len[lst] = ext_pos[i] + ext_len[i] - ext_pos[lst];
								drop_entry(i);
								done = 1;
							end
						end
					end
				end
				OP_CLEAR: begin
					ext_cnt = 0;
					top = 0;
				end
				default: ;
			endcase
			last = g;
			pending.insert(pending.size(), g);
		endfunction

		task check_result(input logic [47:0] d);
			grant_t g;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h", d));
			end else begin
				g = pending.pop_front();
				if (d[19:0] !== g.pos)
					report($sformatf("grant_pos %0d, want %0d", d[19:0], g.pos));
				if (d[40:20] !== g.size)
					report($sformatf("grant_size %0d, want %0d", d[40:20], g.size));
				if (d[42:41] !== g.st)
					report($sformatf("status %0d, want %0d", d[42:41], g.st));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [20:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	alloc_scoreboard sb;
	int          stall_mode;
	int          sent;
	int          n_full;
	int          n_merge_src;
	logic [19:0] held_pos[$];
	logic [20:0] held_size[$];

	first_fit_extent_allocator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("DONE: errors detected");
		$finish;
	end

	always @(negedge clk) begin
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= ~m_axis_tready;
		endcase
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);

	task automatic send(input op_t op, input logic [20:0] sz, input logic [19:0] fpos);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, fpos, sz, op};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, sz, fpos);
		sent++;
		if (sb.last.st == ST_FULL)
			n_full++;
		if (op == OP_ALLOC && sb.last.st == ST_OK && sb.last.size < 70000) begin
			held_pos.insert(held_pos.size(), sb.last.pos);
			held_size.insert(held_size.size(), sb.last.size);
		end
		if (op == OP_CLEAR) begin
			held_pos.delete();
			held_size.delete();
		end
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic set_pool_limit(input logic [20:0] v);
		pause(0);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
	endtask

	task automatic random_request();
		int          r, k;
		logic [19:0] p;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			send(OP_ALLOC, 21'($urandom_range(1, ($urandom_range(0, 9) == 0) ? 4096 : 64)),
				20'd0);
		end else if (r < 78) begin
			if (held_pos.size() == 0) begin
				send(OP_FREE, 21'($urandom_range(1, 64)), 20'($urandom_range(0, 4095)));
			end else begin
				k = $urandom_range(0, held_pos.size() - 1);
				send(OP_FREE, held_size[k], held_pos[k]);
				held_pos.delete(k);
				held_size.delete(k);
				n_merge_src++;
			end
		end else if (r < 82) begin
			send(OP_FREE, 21'($urandom_range(0, 1048576)), 20'($urandom_range(0, 1048575)));
		end else if (r < 86) begin
			send(($urandom_range(0, 1) != 0) ? OP_FREE : OP_ALLOC, 21'd0, 20'($urandom));
		end else if (r < 88) begin
			send(OP_NONE, 21'($urandom_range(0, 1048576)), 20'($urandom));
		end else if (r < 90) begin
			send(OP_CLEAR, 21'($urandom_range(0, 1048576)), 20'($urandom));
		end else if (r < 97) begin
			send(OP_ALLOC, 21'($urandom_range(1, 1048576)), 20'd0);
		end else begin
			// scattered frees to fill the list
			p = 20'($urandom_range(0, 1000000));
			for (int i = 0; i < 36; i++)
				send(OP_FREE, 21'($urandom_range(1, 4)), 20'(p + 8 * i));
		end
	endtask

	initial begin
		logic [20:0] limits[5];
		sb = new();
		sent = 0;
		n_full = 0;
		n_merge_src = 0;
		stall_mode = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send(OP_ALLOC, 0, 0);
		send(OP_FREE, 0, 20'hFFFFF);
		send(OP_NONE, 21'h1FFFFF, 20'hFFFFF);
		send(OP_ALLOC, 1, 0);
		send(OP_ALLOC, 1048576, 0);
		send(OP_CLEAR, 0, 0);
		send(OP_ALLOC, 1048576, 0);
		send(OP_ALLOC, 1, 0);
		send(OP_CLEAR, 0, 0);
		send(OP_FREE, 1048576, 20'hFFFFF);
		send(OP_FREE, 16, 0);
		send(OP_FREE, 16, 32);
		send(OP_FREE, 16, 16);
		send(OP_ALLOC, 8, 0);
		send(OP_ALLOC, 40, 0);
		send(OP_ALLOC, 8, 0);
		send(OP_ALLOC, 2, 0);
		send(OP_CLEAR, 0, 0);
		set_pool_limit(1);
		send(OP_ALLOC, 1, 0);
		send(OP_ALLOC, 1, 0);
		send(OP_CLEAR, 0, 0);

		limits = '{1048576, 300, 4096, 1, 1048576};
		foreach (limits[ph]) begin
			set_pool_limit(limits[ph]);
			send(OP_CLEAR, 0, 0);
			for (int n = 0; n < 130; ) begin
				stall_mode = $urandom_range(0, 3);
				for (int b = $urandom_range(1, 20); b > 0; b--) begin
					random_request();
					n++;
				end
				if ($urandom_range(0, 2) != 0)
					pause($urandom_range(1, 12));
			end
		end

		pause(0);
		stall_mode = 1;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("Run covered %0d requests (%0d frees of granted extents, %0d list-full drops)",
			sent, n_merge_src, n_full);
		$display("over six pool limits; %0d results checked", sb.checked);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/ffea_pkg.sv
hdl/ffea_list_ram.sv
hdl/first_fit_extent_allocator_core.sv
test/tb_first_fit_extent_allocator_core.sv
